>>> rtl/swept_box_collision_macros.svh
// assertion macros used by the checker file
`ifndef SWEPT_BOX_COLLISION_MACROS_SVH
`define SWEPT_BOX_COLLISION_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SBC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sbc_pkg.sv
// types and constants of the swept box collision pipeline
package sbc_pkg;

  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int FT_W    = 16;
  localparam int N_W     = 27;
  localparam int NABS_W  = N_W - 1;
  localparam int D_W     = 40;
  localparam int DABS_W  = D_W - 1;
  localparam int QBITS   = 17;
  localparam int NUM_SHIFT = 31;
  localparam int REM_W   = NABS_W + NUM_SHIFT;
  localparam int OVF_SHIFT = NUM_SHIFT - QBITS;
  localparam int T_W     = 18;
  localparam int HT_W    = 17;
  localparam int ORG_W   = 26;
  localparam int NRM_W   = 2;
  localparam int PROD_W  = D_W + HT_W + 1;
  localparam int SUM_W   = 60;
  localparam int FRAC_SHIFT = 32;
  localparam int NUM_SLABS = 4;
  localparam int DIV_STEPS = 3;

  localparam logic signed [T_W-1:0] T_HI  = 18'sd65537;
  localparam logic signed [T_W-1:0] T_ONE = 18'sd65536;
  localparam logic signed [T_W-1:0] T_LO  = -18'sd1;
  localparam logic signed [T_W-1:0] T_ZERO = 18'sd0;

  localparam logic signed [NRM_W-1:0] NRM_POS  = 2'sd1;
  localparam logic signed [NRM_W-1:0] NRM_NEG  = -2'sd1;
  localparam logic signed [NRM_W-1:0] NRM_ZERO = 2'sd0;

  localparam logic signed [POS_W+3:0] POS_MAX = 28'sd8388607;
  localparam logic signed [POS_W+3:0] POS_MIN = -28'sd8388608;

  // slab index order
  localparam int SLAB_NX = 0;
  localparam int SLAB_FX = 1;
  localparam int SLAB_NY = 2;
  localparam int SLAB_FY = 3;

  typedef struct packed {
    logic              bad;
    logic              neg;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [DABS_W-1:0] den;
    logic [QBITS-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic                  bad;
    logic signed [T_W-1:0] t;
  } slab_t;

  typedef struct packed {
    logic                    miss;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic signed [ORG_W-1:0] ox2;
    logic signed [ORG_W-1:0] oy2;
  } side_t;

endpackage

>>> rtl/swept_box_collision.sv
// top level of the swept box collision pipeline
//
// usage:
//   one word in per box pair on the in channel (in_valid_i / in_ready_o),
//   one result word out on the out channel (out_valid_o / out_ready_i)
//   each input word yields exactly one result word, in order
//   the mover's box is swept along vel * step_dt against the static box
//   grown by the mover's size, using the slab test on four slab times
// timing:
//   the pipe is 5 + ceil(17 / DivSteps) register stages deep, 11 at the default
//   of three quotient bits per divider stage
//   throughput is one word per cycle while the output does not stall; the
//   four slab dividers are the longest part and set the depth, each stage
//   retiring DivSteps bits
// stall:
//   the whole pipe holds while the output word waits and out_ready_i is
//   low; empty stages do not fill either, and in_ready_o stays low until
//   the waiting output word is taken
// reset:
//   rst_ni clears only the valid bits; no word is in flight after reset
//   and no clearing pass is needed
module swept_box_collision #(
  parameter int DivSteps = sbc_pkg::DIV_STEPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [sbc_pkg::POS_W-1:0] mover_x_i,
  input  logic signed [sbc_pkg::POS_W-1:0] mover_y_i,
  input  logic [sbc_pkg::SIZE_W-1:0]       mover_w_i,
  input  logic [sbc_pkg::SIZE_W-1:0]       mover_h_i,
  input  logic signed [sbc_pkg::POS_W-1:0] block_x_i,
  input  logic signed [sbc_pkg::POS_W-1:0] block_y_i,
  input  logic [sbc_pkg::SIZE_W-1:0]       block_w_i,
  input  logic [sbc_pkg::SIZE_W-1:0]       block_h_i,
  input  logic signed [sbc_pkg::POS_W-1:0] vel_x_i,
  input  logic signed [sbc_pkg::POS_W-1:0] vel_y_i,
  input  logic [sbc_pkg::FT_W-1:0]         step_dt_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic signed [sbc_pkg::POS_W-1:0] contact_x_o,
  output logic signed [sbc_pkg::POS_W-1:0] contact_y_o,
  output logic signed [sbc_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [sbc_pkg::NRM_W-1:0] normal_y_o,
  output logic [sbc_pkg::HT_W-1:0]         hit_time_o
);
  import sbc_pkg::*;

  // front two stages, divider stages, back three stages
  localparam int DivStages = (QBITS + DivSteps - 1) / DivSteps;
  localparam int Lat       = 2 + DivStages + 3;

  logic           en;
  logic [Lat-1:0] vld_q;
  div_t           div_w  [NUM_SLABS];
  slab_t          slab_w [NUM_SLABS];
  side_t          side_w;
  side_t          side_q [DivStages];

  // advance when the output register is empty or being drained
  assign en          = out_ready_i || !vld_q[Lat-1];
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];

  // valid bits ride along with each stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  sbc_front u_front (
    .clk_i        (clk_i),
    .en_i         (en),
    .mover_x_i    (mover_x_i),
    .mover_y_i    (mover_y_i),
    .mover_w_i    (mover_w_i),
    .mover_h_i    (mover_h_i),
    .block_x_i    (block_x_i),
    .block_y_i    (block_y_i),
    .block_w_i    (block_w_i),
    .block_h_i    (block_h_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .step_dt_i    (step_dt_i),
    .div_o        (div_w),
    .side_o       (side_w)
  );

  // one divider per slab edge: near x, far x, near y, far y
  for (genvar i = 0; i < NUM_SLABS; i++) begin : g_div
    sbc_div #(
      .Steps (DivSteps)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .div_i  (div_w[i]),
      .slab_o (slab_w[i])
    );
  end

  // ray data waits alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_w;
      for (int s = 1; s < DivStages; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  sbc_back u_back (
    .clk_i       (clk_i),
    .en_i        (en),
    .slab_i      (slab_w),
    .side_i      (side_q[DivStages-1]),
    .hit_o       (hit_o),
    .contact_x_o (contact_x_o),
    .contact_y_o (contact_y_o),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .hit_time_o  (hit_time_o)
  );

endmodule

>>> rtl/sbc_front.sv
// front stages: ray setup and slab divider preparation
module sbc_front (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [sbc_pkg::POS_W-1:0] mover_x_i,
  input  logic signed [sbc_pkg::POS_W-1:0] mover_y_i,
  input  logic [sbc_pkg::SIZE_W-1:0]      mover_w_i,
  input  logic [sbc_pkg::SIZE_W-1:0]      mover_h_i,
  input  logic signed [sbc_pkg::POS_W-1:0] block_x_i,
  input  logic signed [sbc_pkg::POS_W-1:0] block_y_i,
  input  logic [sbc_pkg::SIZE_W-1:0]      block_w_i,
  input  logic [sbc_pkg::SIZE_W-1:0]      block_h_i,
  input  logic signed [sbc_pkg::POS_W-1:0] vel_x_i,
  input  logic signed [sbc_pkg::POS_W-1:0] vel_y_i,
  input  logic [sbc_pkg::FT_W-1:0]        step_dt_i,
  output sbc_pkg::div_t                   div_o [sbc_pkg::NUM_SLABS],
  output sbc_pkg::side_t                  side_o
);
  import sbc_pkg::*;

  logic signed [N_W-1:0] mx, my, mw, mh, bx, by, bw, bh, ox2, oy2;
  logic signed [D_W:0]   dx_full, dy_full;
  logic signed [N_W-1:0] n_d [NUM_SLABS];
  logic signed [N_W-1:0] n_q [NUM_SLABS];
  logic signed [D_W-1:0] dx_q, dy_q;
  logic signed [ORG_W-1:0] ox2_q, oy2_q;
  logic                  miss_q;
  div_t                  div_d [NUM_SLABS];
  div_t                  div_q [NUM_SLABS];
  side_t                 side_q;

  // stage one: direction products and slab distances in half pixels
  always_comb begin
    mx  = N_W'(mover_x_i);
    my  = N_W'(mover_y_i);
    mw  = N_W'($signed({1'b0, mover_w_i}));
    mh  = N_W'($signed({1'b0, mover_h_i}));
    bx  = N_W'(block_x_i);
    by  = N_W'(block_y_i);
    bw  = N_W'($signed({1'b0, block_w_i}));
    bh  = N_W'($signed({1'b0, block_h_i}));
    ox2 = (mx <<< 1) + mw;
    oy2 = (my <<< 1) + mh;
    n_d[SLAB_NX] = (bx <<< 1) - mw - ox2;
    n_d[SLAB_FX] = (bx <<< 1) + (bw <<< 1) + mw - ox2;
    n_d[SLAB_NY] = (by <<< 1) - mh - oy2;
    n_d[SLAB_FY] = (by <<< 1) + (bh <<< 1) + mh - oy2;
    dx_full = vel_x_i * $signed({1'b0, step_dt_i});
    dy_full = vel_y_i * $signed({1'b0, step_dt_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      dx_q   <= dx_full[D_W-1:0];
      dy_q   <= dy_full[D_W-1:0];
      ox2_q  <= ORG_W'(ox2);
      oy2_q  <= ORG_W'(oy2);
      miss_q <= (vel_x_i == '0) && (vel_y_i == '0);
    end
  end

  // stage two: signs, infinities, overflow and divider seed
  always_comb begin
    for (int i = 0; i < NUM_SLABS; i++) begin
      logic signed [D_W-1:0] d;
      logic signed [N_W-1:0] na;
      logic signed [D_W-1:0] da;
      logic nneg, nz, dz, dneg;
      d    = (i < 2) ? dx_q : dy_q;
      nneg = n_q[i][N_W-1];
      nz   = (n_q[i] == '0);
      dz   = (d == '0);
      dneg = d[D_W-1];
      na   = nneg ? -n_q[i] : n_q[i];
      da   = dneg ? -d : d;
      div_d[i].rem = {na[NABS_W-1:0], {NUM_SHIFT{1'b0}}};
      div_d[i].den = da[DABS_W-1:0];
      div_d[i].quo = '0;
      if (dz) begin
        div_d[i].bad = nz;
        div_d[i].neg = nneg;
        div_d[i].sat = !nneg && !nz;
      end else begin
        div_d[i].bad = 1'b0;
        div_d[i].neg = !nz && (nneg ^ dneg);
        div_d[i].sat = !(!nz && (nneg ^ dneg)) &&
                       ({na[NABS_W-1:0], {OVF_SHIFT{1'b0}}} >= {1'b0, da[DABS_W-1:0]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q       <= div_d;
      side_q.miss <= miss_q;
      side_q.dx   <= dx_q;
      side_q.dy   <= dy_q;
      side_q.ox2  <= ox2_q;
      side_q.oy2  <= oy2_q;
    end
  end

  assign div_o  = div_q;
  assign side_o = side_q;

endmodule

>>> rtl/sbc_div.sv
// pipelined restoring divider for one slab time, clamped result
module sbc_div #(
  parameter int Steps = sbc_pkg::DIV_STEPS
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  sbc_pkg::div_t  div_i,
  output sbc_pkg::slab_t slab_o
);
  import sbc_pkg::*;

  localparam int Stages = (QBITS + Steps - 1) / Steps;

  div_t stg_q [Stages];
  div_t stg_d [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    always_comb begin
      logic [REM_W-1:0] sh;
      sh = '0;
      stg_d[s] = (s == 0) ? div_i : stg_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < Steps; j++) begin
        if (s * Steps + j < QBITS) begin
          sh = REM_W'(stg_d[s].den) << (QBITS - 1 - (s * Steps + j));
          if (stg_d[s].rem >= sh) begin
            stg_d[s].rem = stg_d[s].rem - sh;
            stg_d[s].quo[QBITS - 1 - (s * Steps + j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // clamp to just outside the unit window
  always_comb begin
    slab_o.bad = stg_q[Stages-1].bad;
    if (stg_q[Stages-1].bad) begin
      slab_o.t = T_ZERO;
    end else if (stg_q[Stages-1].neg) begin
      slab_o.t = T_LO;
    end else if (stg_q[Stages-1].sat || ($signed({1'b0, stg_q[Stages-1].quo}) > T_HI)) begin
      slab_o.t = T_HI;
    end else begin
      slab_o.t = $signed({1'b0, stg_q[Stages-1].quo});
    end
  end

endmodule

>>> rtl/sbc_back.sv
// back stages: hit window, normal, contact point and output word
module sbc_back (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  sbc_pkg::slab_t                    slab_i [sbc_pkg::NUM_SLABS],
  input  sbc_pkg::side_t                    side_i,
  output logic                              hit_o,
  output logic signed [sbc_pkg::POS_W-1:0]  contact_x_o,
  output logic signed [sbc_pkg::POS_W-1:0]  contact_y_o,
  output logic signed [sbc_pkg::NRM_W-1:0]  normal_x_o,
  output logic signed [sbc_pkg::NRM_W-1:0]  normal_y_o,
  output logic [sbc_pkg::HT_W-1:0]          hit_time_o
);
  import sbc_pkg::*;

  logic signed [T_W-1:0] nx, fx, ny, fy, thn, thf;
  logic                  hit_d;
  logic signed [NRM_W-1:0] nrx_d, nry_d;

  logic                    hit1_q, hit2_q;
  logic signed [NRM_W-1:0] nrx1_q, nry1_q, nrx2_q, nry2_q;
  logic [HT_W-1:0]         thn1_q, thn2_q;
  logic signed [D_W-1:0]   dx1_q, dy1_q;
  logic signed [ORG_W-1:0] ox1_q, oy1_q, ox2_q, oy2_q;
  logic signed [PROD_W-1:0] px2_q, py2_q;
  logic signed [PROD_W-1:0] px_d, py_d;

  logic signed [SUM_W-1:0]   sx, sy;
  logic signed [POS_W+3:0]   cx, cy;
  logic signed [POS_W-1:0]   cx_sat, cy_sat;

  logic                    hit_q;
  logic signed [POS_W-1:0] cx_q, cy_q;
  logic signed [NRM_W-1:0] nrx_q, nry_q;
  logic [HT_W-1:0]         ht_q;

  always_comb begin
    nx  = (slab_i[SLAB_NX].t > slab_i[SLAB_FX].t) ? slab_i[SLAB_FX].t : slab_i[SLAB_NX].t;
    fx  = (slab_i[SLAB_NX].t > slab_i[SLAB_FX].t) ? slab_i[SLAB_NX].t : slab_i[SLAB_FX].t;
    ny  = (slab_i[SLAB_NY].t > slab_i[SLAB_FY].t) ? slab_i[SLAB_FY].t : slab_i[SLAB_NY].t;
    fy  = (slab_i[SLAB_NY].t > slab_i[SLAB_FY].t) ? slab_i[SLAB_NY].t : slab_i[SLAB_FY].t;
    thn = (nx > ny) ? nx : ny;
    thf = (fx < fy) ? fx : fy;
    hit_d = !side_i.miss && !slab_i[SLAB_NX].bad && !slab_i[SLAB_FX].bad &&
            !slab_i[SLAB_NY].bad && !slab_i[SLAB_FY].bad &&
            !(nx > fy) && !(ny > fx) && (thf >= T_ZERO) &&
            (thn >= T_ZERO) && (thn <= T_ONE);
    nrx_d = NRM_ZERO;
    nry_d = NRM_ZERO;
    if (nx > ny) begin
      nrx_d = side_i.dx[D_W-1] ? NRM_POS : NRM_NEG;
    end else if (nx < ny) begin
      nry_d = side_i.dy[D_W-1] ? NRM_POS : NRM_NEG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit1_q <= hit_d;
      nrx1_q <= nrx_d;
      nry1_q <= nry_d;
      thn1_q <= thn[HT_W-1:0];
      dx1_q  <= side_i.dx;
      dy1_q  <= side_i.dy;
      ox1_q  <= side_i.ox2;
      oy1_q  <= side_i.oy2;
    end
  end

  // travel along the ray
  always_comb begin
    px_d = dx1_q * $signed({1'b0, thn1_q});
    py_d = dy1_q * $signed({1'b0, thn1_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit2_q <= hit1_q;
      nrx2_q <= nrx1_q;
      nry2_q <= nry1_q;
      thn2_q <= thn1_q;
      px2_q  <= px_d;
      py2_q  <= py_d;
      ox2_q  <= ox1_q;
      oy2_q  <= oy1_q;
    end
  end

  // floor to q.8 and saturate
  always_comb begin
    sx = (SUM_W'(ox2_q) <<< NUM_SHIFT) + SUM_W'(px2_q);
    sy = (SUM_W'(oy2_q) <<< NUM_SHIFT) + SUM_W'(py2_q);
    cx = sx[SUM_W-1:FRAC_SHIFT];
    cy = sy[SUM_W-1:FRAC_SHIFT];
    if (cx > POS_MAX) begin
      cx_sat = POS_MAX[POS_W-1:0];
    end else if (cx < POS_MIN) begin
      cx_sat = POS_MIN[POS_W-1:0];
    end else begin
      cx_sat = cx[POS_W-1:0];
    end
    if (cy > POS_MAX) begin
      cy_sat = POS_MAX[POS_W-1:0];
    end else if (cy < POS_MIN) begin
      cy_sat = POS_MIN[POS_W-1:0];
    end else begin
      cy_sat = cy[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit2_q;
      cx_q  <= hit2_q ? cx_sat : '0;
      cy_q  <= hit2_q ? cy_sat : '0;
      nrx_q <= hit2_q ? nrx2_q : NRM_ZERO;
      nry_q <= hit2_q ? nry2_q : NRM_ZERO;
      ht_q  <= hit2_q ? thn2_q : '0;
    end
  end

  assign hit_o       = hit_q;
  assign contact_x_o = cx_q;
  assign contact_y_o = cy_q;
  assign normal_x_o  = nrx_q;
  assign normal_y_o  = nry_q;
  assign hit_time_o  = ht_q;

endmodule

>>> rtl/sbc_checker.sv
// port level checks for the swept box collision block
`include "swept_box_collision_macros.svh"

module sbc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             hit_o,
  input logic signed [sbc_pkg::POS_W-1:0] contact_x_o,
  input logic signed [sbc_pkg::POS_W-1:0] contact_y_o,
  input logic signed [sbc_pkg::NRM_W-1:0] normal_x_o,
  input logic signed [sbc_pkg::NRM_W-1:0] normal_y_o,
  input logic [sbc_pkg::HT_W-1:0]         hit_time_o
);
  import sbc_pkg::*;

  `SBC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output word dropped")
  `SBC_ASSERT_IMPLY(a_miss_zero, out_valid_o && !hit_o, contact_x_o == '0 && contact_y_o == '0 && normal_x_o == NRM_ZERO && normal_y_o == NRM_ZERO && hit_time_o == '0, "miss word not zero")
  `SBC_ASSERT_IMPLY(a_time_range, out_valid_o && hit_o, hit_time_o <= HT_W'(65536), "hit time beyond step")
  `SBC_ASSERT_IMPLY(a_one_normal, out_valid_o, normal_x_o == NRM_ZERO || normal_y_o == NRM_ZERO, "two normal axes set")

endmodule

bind swept_box_collision sbc_checker u_sbc_checker (.*);
